/* sv/button_click_event_classifier_macros.svh */
// Assertion helpers used by the burst queue RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BUTTON_CLICK_EVENT_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_EVENT_CLASSIFIER_MACROS_SVH

// Condition must hold on every cycle out of reset.
`define BCEC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the cycle after.
`define BCEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bcec_pkg.sv */
package bcec_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int TIME_IN_W      = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_EVENTS     = 4;
    localparam int EV_IDX_W       = 2;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        EV_CHANGED  = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_CLICK    = 3'd3,
        EV_LONG     = 3'd4,
        EV_DOUBLE   = 3'd5,
        EV_HOLD     = 3'd6,
        EV_REPEAT   = 3'd7
    } evt_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LOW      = 3'd0,
        REG_HOLD_INTERVAL   = 3'd1,
        REG_REPEAT_ENABLE   = 3'd2,
        REG_REPEAT_INTERVAL = 3'd3,
        REG_DCLICK_INTERVAL = 3'd4,
        REG_PREVENT_CLICK   = 3'd5
    } cfg_idx_t;

    // All events caused by one tick, in emission order.
    typedef struct packed {
        logic [EV_IDX_W-1:0]       last_idx;
        evt_code_t [MAX_EVENTS-1:0] codes;
    } bcec_burst_t;

    typedef struct packed {
        logic empty;
        logic full;
    } bcec_q_status_t;

endpackage

/* sv/bcec_if.sv */
interface bcec_tick_if;
    import bcec_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 level;
    logic [TIME_IN_W-1:0] time_ms;
    modport source (output valid, output level, output time_ms, input ready);
    modport sink   (input valid, input level, input time_ms, output ready);
endinterface

interface bcec_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic       last;
    modport source (output valid, output event_code, output last, input ready);
    modport sink   (input valid, input event_code, input last, output ready);
endinterface

interface bcec_cfg_if;
    import bcec_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/button_click_event_classifier.sv */
// A tick's burst is written into the burst queue; its first event is offered once it reaches the head.
// The input takes one tick per cycle while the burst queue is not full; the output emits one
// event per cycle while evt.ready is high, so a tick with n events (1 to 4) needs n transactions.
// The event serializer in the back part sets the sustained rate.
// Reset (rst_n, async, active low): registers at their defaults, button released,
// timestamps, click count and hold flag cleared, event queue emptied.
module button_click_event_classifier #(
    parameter int TIME_WIDTH = bcec_pkg::TIME_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bcec_tick_if.sink     tick,
    bcec_cfg_if.sink      cfg,
    bcec_event_if.source  evt
);
    import bcec_pkg::*;

    // Front: config registers, button state and the per-tick classifier.
    // It builds the whole event burst of a tick combinationally.
    bcec_burst_t    push_burst;
    bcec_burst_t    head_burst;
    bcec_q_status_t q_status;
    logic           push;
    logic           pop;

    bcec_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .burst    (push_burst)
    );

    // Burst queue: decouples the classifier from output backpressure.
    // Ticks keep flowing while earlier bursts are still being drained.
    bcec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_burst (push_burst),
        .pop      (pop),
        .head     (head_burst),
        .status   (q_status)
    );

    // Back: walks the head burst one event per transaction, flags the
    // final one and releases the entry after it is taken.
    bcec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_burst),
        .q_status (q_status),
        .pop      (pop),
        .evt      (evt)
    );

endmodule

/* sv/bcec_front.sv */
module bcec_front #(
    parameter int TIME_WIDTH = bcec_pkg::TIME_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    bcec_tick_if.sink              tick,
    bcec_cfg_if.sink               cfg,
    input  bcec_pkg::bcec_q_status_t q_status,
    output logic                   push,
    output bcec_pkg::bcec_burst_t  burst
);
    import bcec_pkg::*;

    localparam int NCAND = 8;

    // configuration
    logic                  active_low_reg;
    logic [CFG_DATA_W-1:0] hold_interval_reg;
    logic                  repeat_enable_reg;
    logic [CFG_DATA_W-1:0] repeat_interval_reg;
    logic [CFG_DATA_W-1:0] dclick_interval_reg;
    logic                  prevent_click_reg;

    // button state
    logic                  prev_level_reg;
    logic [TIME_WIDTH-1:0] press_time_reg, press_time_next;
    logic [TIME_WIDTH-1:0] repeat_time_reg, repeat_time_next;
    logic [1:0]            click_count_reg, click_count_next;
    logic                  hold_flag_reg, hold_flag_next;

    logic                  accept;
    logic [TIME_WIDTH-1:0] now, e_press, e_rep, e_down;
    logic                  is_down, changed, press_edge, release_edge;
    logic                  long_rel, defer_fire, hold_en, rep1, rep2;
    logic [1:0]            cc1, cc2;
    logic                  rel_en;
    evt_code_t             rel_code;
    logic [NCAND-1:0]      cand_en;
    evt_code_t [NCAND-1:0] cand_code;
    logic [2:0]            n_ev;

    assign cfg.ready  = 1'b1;
    assign tick.ready = !q_status.full;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            active_low_reg      <= 1'b1;
            hold_interval_reg   <= CFG_DATA_W'(1000);
            repeat_enable_reg   <= 1'b0;
            repeat_interval_reg <= CFG_DATA_W'(100);
            dclick_interval_reg <= '0;
            prevent_click_reg   <= 1'b0;
        end else if (cfg.valid) begin
            case (cfg_idx_t'(cfg.index))
                REG_ACTIVE_LOW:      active_low_reg      <= cfg.data[0];
                REG_HOLD_INTERVAL:   hold_interval_reg   <= cfg.data;
                REG_REPEAT_ENABLE:   repeat_enable_reg   <= cfg.data[0];
                REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg.data;
                REG_DCLICK_INTERVAL: dclick_interval_reg <= cfg.data;
                REG_PREVENT_CLICK:   prevent_click_reg   <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        now          = TIME_WIDTH'(tick.time_ms);
        is_down      = active_low_reg ? !tick.level : tick.level;
        changed      = tick.level != prev_level_reg;
        press_edge   = changed && is_down;
        release_edge = changed && !is_down;
        e_press      = now - press_time_reg;
        e_rep        = now - repeat_time_reg;
        e_down       = (press_edge || press_time_reg == '0) ? '0 : e_press;

        long_rel   = (hold_interval_reg != '0) &&
                     (e_press >= TIME_WIDTH'(hold_interval_reg));
        defer_fire = !is_down && (click_count_reg != 2'd0) &&
                     (e_press >= TIME_WIDTH'(dclick_interval_reg));
        cc1        = defer_fire ? 2'd0 : click_count_reg;
        cc2        = (cc1 == 2'd3) ? 2'd3 : cc1 + 2'd1;

        click_count_next = cc1;
        rel_en           = 1'b1;
        rel_code         = EV_CLICK;
        if (long_rel) begin
            rel_code = EV_LONG;
        end else if (dclick_interval_reg != '0) begin
            if (release_edge)
                click_count_next = cc2;
            rel_en   = (cc2 == 2'd1 && !prevent_click_reg) || cc2 == 2'd2;
            rel_code = (cc2 == 2'd2) ? EV_DOUBLE : EV_CLICK;
        end else begin
            rel_code = hold_flag_reg ? EV_LONG : EV_CLICK;
        end

        rep1    = is_down && repeat_enable_reg && hold_flag_reg &&
                  (e_rep >= TIME_WIDTH'(repeat_interval_reg));
        hold_en = is_down && !hold_flag_reg && (hold_interval_reg != '0) &&
                  (e_down >= TIME_WIDTH'(hold_interval_reg));
        rep2    = hold_en && repeat_enable_reg;

        press_time_next  = (is_down && (press_edge || press_time_reg == '0)) ?
                           now : press_time_reg;
        repeat_time_next = (rep1 || rep2) ? now : repeat_time_reg;
        hold_flag_next   = release_edge ? 1'b0 : (hold_en ? 1'b1 : hold_flag_reg);

        // candidates in emission order
        cand_en   = {rep2, hold_en, rep1, release_edge && rel_en, release_edge,
                     press_edge, defer_fire && cc1 == 2'd0 &&
                     click_count_reg == 2'd1 && prevent_click_reg, changed};
        cand_code[0] = EV_CHANGED;
        cand_code[1] = long_rel ? EV_LONG : EV_CLICK;
        cand_code[2] = EV_PRESSED;
        cand_code[3] = EV_RELEASED;
        cand_code[4] = rel_code;
        cand_code[5] = EV_REPEAT;
        cand_code[6] = EV_HOLD;
        cand_code[7] = EV_REPEAT;

        for (int j = 0; j < MAX_EVENTS; j++)
            burst.codes[j] = EV_CHANGED;
        n_ev = 3'd0;
        for (int i = 0; i < NCAND; i++) begin
            if (cand_en[i] && n_ev < 3'(MAX_EVENTS)) begin
                burst.codes[n_ev[EV_IDX_W-1:0]] = cand_code[i];
                n_ev = n_ev + 3'd1;
            end
        end
        burst.last_idx = EV_IDX_W'(n_ev - 3'd1);
        push           = accept && (n_ev != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_level_reg  <= 1'b1;
            press_time_reg  <= '0;
            repeat_time_reg <= '0;
            click_count_reg <= 2'd0;
            hold_flag_reg   <= 1'b0;
        end else if (accept) begin
            prev_level_reg  <= tick.level;
            press_time_reg  <= press_time_next;
            repeat_time_reg <= repeat_time_next;
            click_count_reg <= click_count_next;
            hold_flag_reg   <= hold_flag_next;
        end
    end

endmodule

/* sv/bcec_queue.sv */
`include "button_click_event_classifier_macros.svh"

module bcec_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bcec_pkg::bcec_burst_t   wr_burst,
    input  logic                    pop,
    output bcec_pkg::bcec_burst_t   head,
    output bcec_pkg::bcec_q_status_t status
);
    import bcec_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bcec_burst_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk) begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_burst;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: ;
            endcase
        end
    end

    `BCEC_ASSERT_ALWAYS(a_cnt_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `BCEC_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, count_reg == $past(count_reg) + CNT_W'(1), "push lost")
    `BCEC_ASSERT_NEXT(a_cnt_dn, do_pop && !do_push, count_reg == $past(count_reg) - CNT_W'(1), "pop lost")
    `BCEC_ASSERT_ALWAYS(a_ptr_gap, (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)) ? (wr_ptr_reg == rd_ptr_reg) : (wr_ptr_reg != rd_ptr_reg), "pointer and count disagree")

endmodule

/* sv/bcec_back.sv */
module bcec_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bcec_pkg::bcec_burst_t    head,
    input  bcec_pkg::bcec_q_status_t q_status,
    output logic                     pop,
    bcec_event_if.source             evt
);
    import bcec_pkg::*;

    logic [EV_IDX_W-1:0] idx_reg, idx_next;
    logic                take;

    always_comb
    begin
        evt.valid      = !q_status.empty;
        evt.event_code = head.codes[idx_reg];
        evt.last       = (idx_reg == head.last_idx);
        take           = evt.valid && evt.ready;
        pop            = take && evt.last;
        idx_next       = idx_reg;
        if (take)
            idx_next = evt.last ? '0 : idx_reg + EV_IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule
